// ===== design/qte_pkg.sv =====
`timescale 1ns / 1ps
package qte_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int ANG_TABLE_LEN = 24;
  localparam int NUM_STEPS     = (CORDIC_STEPS < ANG_TABLE_LEN) ? CORDIC_STEPS : ANG_TABLE_LEN;
  localparam int STEP_W        = 5;
  localparam int CW            = 37;   // CORDIC vector width
  localparam int AW            = 27;   // angle accumulator, 2^-16 degree
  localparam int RW            = AW - 9; // angle after rounding to 1/128 degree
  localparam int NW            = 58;   // square root operand width
  localparam int ISQRT_STAGES  = 29;
  localparam int PITCH_LIMIT   = 11520;
  localparam int TURN_LIMIT    = 23040;

  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
  } quat_t;

  typedef struct packed {
    logic signed [14:0] pitch_deg;
    logic signed [15:0] roll_deg;
    logic signed [15:0] yaw_deg;
  } euler_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic [NW-1:0] n;
    logic [NW-1:0] res;
  } root_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [AW-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic signed [AW-1:0] r;
    case (i)
      5'd0:  r = AW'(2949120);
      5'd1:  r = AW'(1740967);
      5'd2:  r = AW'(919879);
      5'd3:  r = AW'(466945);
      5'd4:  r = AW'(234379);
      5'd5:  r = AW'(117304);
      5'd6:  r = AW'(58666);
      5'd7:  r = AW'(29335);
      5'd8:  r = AW'(14668);
      5'd9:  r = AW'(7334);
      5'd10: r = AW'(3667);
      5'd11: r = AW'(1833);
      5'd12: r = AW'(917);
      5'd13: r = AW'(458);
      5'd14: r = AW'(229);
      5'd15: r = AW'(115);
      5'd16: r = AW'(57);
      5'd17: r = AW'(29);
      5'd18: r = AW'(14);
      5'd19: r = AW'(7);
      5'd20: r = AW'(4);
      5'd21: r = AW'(2);
      5'd22: r = AW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // turn a left half plane vector by 90 degrees, preload the angle
  function automatic vec_t preload(input logic signed [CW-1:0] ny,
                                   input logic signed [CW-1:0] nx);
    vec_t v;
    v.zero = (nx == '0) && (ny == '0);
    if (nx < 0) begin
      if (ny >= 0) begin
        v.x   = ny;
        v.y   = -nx;
        v.acc = AW'(5898240);
      end else begin
        v.x   = -ny;
        v.y   = nx;
        v.acc = AW'(-5898240);
      end
    end else begin
      v.x   = nx;
      v.y   = ny;
      v.acc = '0;
    end
    return v;
  endfunction

  // round the accumulator to 1/128 degree, floor shift
  function automatic logic signed [RW-1:0] finish(input vec_t v);
    logic signed [AW-1:0] t;
    t = v.acc + AW'(256);
    if (v.zero) return '0;
    return t[AW-1:9];
  endfunction

endpackage

// ===== design/quaternion_to_euler_degrees.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Valid        Stall        Payload
// in       in   in_valid_i   in_stall_o   in_req_i  (quat_t)
// out      out  out_valid_o  out_stall_i  out_res_o (euler_t)
//
// One request accepted per cycle while no stalled result waits; the pipeline runs
// through the 29 square root cells and the CORDIC cell row.
// Reset clears the stage valid bits only.
// A stalled result freezes the whole pipeline; in_stall_o follows out_stall_i
// only while a result waits.
module quaternion_to_euler_degrees import qte_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  quat_t  in_req_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output euler_t out_res_o
);

  localparam int LAT = 34 + NUM_STEPS;

  typedef struct packed {
    logic signed [29:0] s;
    logic signed [33:0] roll_y;
    logic signed [33:0] roll_x;
    logic signed [33:0] yaw_y;
    logic signed [33:0] yaw_x;
  } side_t;

  logic           en;
  logic [LAT-1:0] v_q;

  logic signed [31:0] wy_q, xz_q, wx_q, yz_q, wz_q, xy_q, ww_q, xx_q, zz_q;
  logic signed [33:0] s_raw;
  side_t              side_d, side2_q;
  side_t              side_q [ISQRT_STAGES+1];
  logic signed [59:0] ss;
  root_t              root_w [ISQRT_STAGES+1];
  root_t              root0_q;
  vec_t               vec_w  [3][NUM_STEPS+1];
  vec_t               pre_q  [3];
  logic signed [RW-1:0] ang  [3];
  euler_t             res_q;

  assign en         = !(v_q[LAT-1] && out_stall_i);
  assign in_stall_o = v_q[LAT-1] && out_stall_i;

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_valid_i};
    end
  end

  // form the products
  always_ff @(posedge clk_i) begin
    if (en) begin
      wy_q <= in_req_i.q_w * in_req_i.q_y;
      xz_q <= in_req_i.q_x * in_req_i.q_z;
      wx_q <= in_req_i.q_w * in_req_i.q_x;
      yz_q <= in_req_i.q_y * in_req_i.q_z;
      wz_q <= in_req_i.q_w * in_req_i.q_z;
      xy_q <= in_req_i.q_x * in_req_i.q_y;
      ww_q <= in_req_i.q_w * in_req_i.q_w;
      xx_q <= in_req_i.q_x * in_req_i.q_x;
      zz_q <= in_req_i.q_z * in_req_i.q_z;
    end
  end

  // sum the products, clamp the pitch sine
  always_comb begin
    s_raw = (34'(wy_q) - 34'(xz_q)) <<< 1;
    if (s_raw > 34'sh1000_0000)       side_d.s = 30'sh1000_0000;
    else if (s_raw < -34'sh1000_0000) side_d.s = -30'sh1000_0000;
    else                              side_d.s = s_raw[29:0];
    side_d.roll_y = (34'(wx_q) + 34'(yz_q)) <<< 1;
    side_d.roll_x = ((34'(ww_q) + 34'(zz_q)) <<< 1) - 34'sh1000_0000;
    side_d.yaw_y  = (34'(wz_q) + 34'(xy_q)) <<< 1;
    side_d.yaw_x  = ((34'(ww_q) + 34'(xx_q)) <<< 1) - 34'sh1000_0000;
  end

  always_ff @(posedge clk_i) begin
    if (en) side2_q <= side_d;
  end

  // square the sine, seed the root
  assign ss = side2_q.s * side2_q.s;

  always_ff @(posedge clk_i) begin
    if (en) begin
      root0_q.n   <= (NW'(1) << 56) - ss[NW-1:0];
      root0_q.res <= '0;
      side_q[0]   <= side2_q;
    end
  end

  assign root_w[0] = root0_q;

  for (genvar i = 0; i < ISQRT_STAGES; i++) begin : g_root
    qte_isqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .exp_i  (6'(56 - 2 * i)),
      .root_i (root_w[i]),
      .root_o (root_w[i+1])
    );

    always_ff @(posedge clk_i) begin
      if (en) side_q[i+1] <= side_q[i];
    end
  end

  // preload the three vectors
  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_q[0] <= preload(CW'(side_q[ISQRT_STAGES].s),
                          $signed({8'b0, root_w[ISQRT_STAGES].res[28:0]}));
      pre_q[1] <= preload(CW'(side_q[ISQRT_STAGES].roll_y), CW'(side_q[ISQRT_STAGES].roll_x));
      pre_q[2] <= preload(CW'(side_q[ISQRT_STAGES].yaw_y), CW'(side_q[ISQRT_STAGES].yaw_x));
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign vec_w[l][0] = pre_q[l];
    for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
      qte_cordic_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .step_i (STEP_W'(j)),
        .vec_i  (vec_w[l][j]),
        .vec_o  (vec_w[l][j+1])
      );
    end
    assign ang[l] = finish(vec_w[l][NUM_STEPS]);
  end

  // round and clamp to range
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ang[0] > RW'(PITCH_LIMIT))       res_q.pitch_deg <= 15'(PITCH_LIMIT);
      else if (ang[0] < -RW'(PITCH_LIMIT)) res_q.pitch_deg <= -15'(PITCH_LIMIT);
      else                                 res_q.pitch_deg <= ang[0][14:0];
      if (ang[1] > RW'(TURN_LIMIT))        res_q.roll_deg <= 16'(TURN_LIMIT);
      else if (ang[1] < -RW'(TURN_LIMIT))  res_q.roll_deg <= -16'(TURN_LIMIT);
      else                                 res_q.roll_deg <= ang[1][15:0];
      if (ang[2] > RW'(TURN_LIMIT))        res_q.yaw_deg <= 16'(TURN_LIMIT);
      else if (ang[2] < -RW'(TURN_LIMIT))  res_q.yaw_deg <= -16'(TURN_LIMIT);
      else                                 res_q.yaw_deg <= ang[2][15:0];
    end
  end

  assign out_valid_o = v_q[LAT-1];
  assign out_res_o   = res_q;

`ifndef NO_ASSERTIONS
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q)) else $error("pipeline moved while stalled");
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_res_o.pitch_deg <= 15'sd11520 && out_res_o.pitch_deg >= -15'sd11520))
    else $error("pitch out of range");
  a_turn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_res_o.roll_deg <= 16'sd23040 && out_res_o.roll_deg >= -16'sd23040 &&
                     out_res_o.yaw_deg <= 16'sd23040 && out_res_o.yaw_deg >= -16'sd23040))
    else $error("roll or yaw out of range");
`endif

endmodule

// ===== design/qte_isqrt_cell.sv =====
`timescale 1ns / 1ps
module qte_isqrt_cell import qte_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [5:0]  exp_i,
  input  root_t       root_i,
  output root_t       root_o
);

  logic [NW-1:0] bit_w;
  logic [NW-1:0] sum_w;
  root_t         root_d, root_q;

  // try one result bit
  always_comb begin
    bit_w = NW'(1) << exp_i;
    sum_w = root_i.res + bit_w;
    if (root_i.n >= sum_w) begin
      root_d.n   = root_i.n - sum_w;
      root_d.res = (root_i.res >> 1) + bit_w;
    end else begin
      root_d.n   = root_i.n;
      root_d.res = root_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

// ===== design/qte_cordic_cell.sv =====
`timescale 1ns / 1ps
module qte_cordic_cell import qte_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [STEP_W-1:0] step_i,
  input  vec_t              vec_i,
  output vec_t              vec_o
);

  logic signed [CW-1:0] dx, dy;
  vec_t                 vec_d, vec_q;

  // rotate toward the x axis by atan(2^-step)
  always_comb begin
    dx    = vec_i.y >>> step_i;
    dy    = vec_i.x >>> step_i;
    vec_d = vec_i;
    if (vec_i.y >= 0) begin
      vec_d.x   = vec_i.x + dx;
      vec_d.y   = vec_i.y - dy;
      vec_d.acc = vec_i.acc + atan_step(step_i);
    end else begin
      vec_d.x   = vec_i.x - dx;
      vec_d.y   = vec_i.y + dy;
      vec_d.acc = vec_i.acc - atan_step(step_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) vec_q <= vec_d;
  end

  assign vec_o = vec_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import qte_pkg::*;

  localparam int LATENCY = 34 + NUM_STEPS;
  localparam int RANDOM_ITEMS = 850;

  // directed stimulus row; has_exp marks rows with a known answer
  typedef struct {
    quat_t  q;
    logic   has_exp;
    euler_t exp;
  } stim_row_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  quat_t  in_req_i = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  euler_t out_res_o;

  euler_t    angle_q[$];
  int        error_count = 0;
  int        send_idle_pct = 8;
  int        recv_idle_pct = 62;
  stim_row_t dir_rows[$];

  quaternion_to_euler_degrees u_top (.*);

  always #6 clk_i = ~clk_i;

  // CORDIC vectoring atan2, result in 1/128 degree before clamp
  function automatic longint cordic_angle(longint ny, longint nx);
    longint cx, cy, acc, t, dx, dy;
    longint steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                          29, 14, 7, 4, 2, 1, 0};
    cx = nx; cy = ny; acc = 0;
    if (nx == 0 && ny == 0) return 0;
    if (cx < 0) begin
      if (cy >= 0) begin
        t = cx; cx = cy; cy = -t; acc = 90 * 65536;
      end else begin
        t = cx; cx = -cy; cy = t; acc = -90 * 65536;
      end
    end
    for (int i = 0; i < NUM_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; acc += steps[i];
      end else begin
        cx -= dx; cy += dy; acc -= steps[i];
      end
    end
    return (acc + 256) >>> 9;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return (v < -lim) ? -lim : (v > lim) ? lim : v;
  endfunction

  // floor square root of a non-negative value
  function automatic longint floor_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic euler_t euler_angles(quat_t q);
    longint w, x, y, z, s, c;
    euler_t e;
    w = q.q_w; x = q.q_x; y = q.q_y; z = q.q_z;
    s = clip(2 * (w * y - x * z), 64'sd1 << 28);
    c = floor_sqrt((64'sd1 << 56) - s * s);
    e.pitch_deg = 15'(clip(cordic_angle(s, c), PITCH_LIMIT));
    e.roll_deg = 16'(clip(cordic_angle(2 * (w * x + y * z),
                                       2 * (w * w + z * z) - (64'sd1 << 28)), TURN_LIMIT));
    e.yaw_deg = 16'(clip(cordic_angle(2 * (w * z + x * y),
                                      2 * (w * w + x * x) - (64'sd1 << 28)), TURN_LIMIT));
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic quat_t random_quat();
    quat_t q;
    int mode;
    mode = $urandom_range(0, 3);
    q[63:32] = $urandom();
    q[31:0] = $urandom();
    if (mode == 0) begin
      // bounded quaternion: w within +-16384, x, y, z within +-8192
      q.q_w = 16'($signed($urandom_range(0, 32768)) - 16384);
      q.q_x = 16'($signed($urandom_range(0, 16384)) - 8192);
      q.q_y = 16'($signed($urandom_range(0, 16384)) - 8192);
      q.q_z = 16'($signed($urandom_range(0, 16384)) - 8192);
    end else if (mode == 1) begin
      q.q_x = 16'($signed($urandom_range(0, 8)) - 4);
      q.q_z = 16'($signed($urandom_range(0, 8)) - 4);
    end
    return q;
  endfunction

  function automatic stim_row_t row(int w, int x, int y, int z, logic h,
                                    int p = 0, int r = 0, int yw = 0);
    stim_row_t s;
    s.q = '{16'(w), 16'(x), 16'(y), 16'(z)};
    s.has_exp = h;
    s.exp = '{15'(p), 16'(r), 16'(yw)};
    return s;
  endfunction

  // hold a request until accepted
  task automatic send_request(quat_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // compare accepted results against the oldest expectation
  always @(posedge clk_i) begin
    euler_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (angle_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = angle_q.pop_front();
        if (out_res_o.pitch_deg !== want.pitch_deg)
          report_mismatch("pitch", out_res_o.pitch_deg, want.pitch_deg);
        if (out_res_o.roll_deg !== want.roll_deg)
          report_mismatch("roll", out_res_o.roll_deg, want.roll_deg);
        if (out_res_o.yaw_deg !== want.yaw_deg)
          report_mismatch("yaw", out_res_o.yaw_deg, want.yaw_deg);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("quaternion_to_euler_degrees verification failed");
    $finish;
  end

  initial begin
    stim_row_t s;
    int waited;
    // identity, zero and extreme rows; known answers where obvious
    dir_rows.push_back(row(16384, 0, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(row(0, 0, 0, 0, 1, 0, 23040, 23040));
    dir_rows.push_back(row(11585, 11585, 0, 0, 0));
    dir_rows.push_back(row(11585, 0, 11585, 0, 0));
    dir_rows.push_back(row(11585, 0, -11585, 0, 0));
    dir_rows.push_back(row(11585, 0, 0, 11585, 0));
    dir_rows.push_back(row(0, 16384, 0, 0, 0));
    dir_rows.push_back(row(0, 0, 0, 16384, 0));
    dir_rows.push_back(row(32767, 32767, 32767, 32767, 0));
    dir_rows.push_back(row(-32768, -32768, -32768, -32768, 0));
    dir_rows.push_back(row(32767, 0, 32767, 0, 1, 11520, 0, 0));
    dir_rows.push_back(row(32767, 0, -32768, 0, 1, -11520, 0, 0));
    dir_rows.push_back(row(-32768, 32767, -32768, 32767, 0));
    dir_rows.push_back(row(0, 0, 16384, 0, 0));
    dir_rows.push_back(row(5, -7, 3, 1, 0));
    dir_rows.push_back(row(-16384, 0, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(row(0, 11585, 0, -11585, 0));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 8 : 0;
      if (phase == 0) begin
        foreach (dir_rows[i]) begin
          s = dir_rows[i];
          angle_q.push_back(s.has_exp ? s.exp : euler_angles(s.q));
          send_request(s.q);
        end
      end
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        s.q = random_quat();
        angle_q.push_back(euler_angles(s.q));
        send_request(s.q);
      end
    end
    in_valid_i <= 1'b0;
    // drain
    waited = 0;
    while (angle_q.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (error_count == 0 && angle_q.size() == 0) begin
      $display("quaternion_to_euler_degrees verification clean");
    end else begin
      $display("quaternion_to_euler_degrees verification failed");
    end
    $finish;
  end

endmodule
